/* sv/adpcm_bd_pkg.sv */
// Package for the 4-bit ADPCM block decoder: sizes, register indexes,
// saturation limits and the arithmetic types shared by the decoder RTL.
// No dependencies.
`timescale 1ns / 1ps

package adpcm_bd_pkg;

	// Channel history depth and the index width that follows from it
	localparam int MaxChannels = 8;
	localparam int CH_IDX_W    = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
	localparam int CC_W        = $clog2(MaxChannels + 1);

	// Field and register widths
	localparam int CH_W       = 3;
	localparam int SIB_W      = 9;
	localparam int POS_W      = 8;
	localparam int COEF_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRED_COEFF_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRED_COEFF_B = 2'd3;

	// Input command codes
	localparam logic CMD_DATA    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Reset values of the configuration registers and the minimum slice byte count
	localparam logic [3:0]        CC_RESET = 4'd1;
	localparam logic [POS_W-1:0]  BB_RESET = 8'd18;
	localparam logic [POS_W-1:0]  BB_MIN   = 8'd3;

	// Prediction shift and output limits
	localparam int Q_SHIFT = 12;
	localparam logic signed [31:0] SAT_MAX = 32'sd32767;
	localparam logic signed [31:0] SAT_MIN = -32'sd32768;

	typedef logic signed [15:0] sample_t;
	typedef logic signed [31:0] prod_t;

endpackage

/* sv/adpcm_4bit_block_decoder_unit.sv */
// Top level of the 4-bit ADPCM block decoder: byte parser, shared multiplier
// sequencer, per-channel history and output register.
// Depends on adpcm_bd_pkg.
`timescale 1ns / 1ps

// Usage:
// The input stream (s_axis_*) carries one stream byte per transfer in tdata and
// a command bit in tuser: 0 feeds the byte to the decoder, 1 clears all channel
// history and restarts at a block boundary. The first two bytes of each channel
// slice load the big-endian scale and give no output; every later byte gives
// two samples on the output stream (m_axis_*), high nibble first.
// Scale bytes and restart commands leave the sequencer idle. A nibble byte
// keeps the block busy until both its samples are written, which an output
// stall delays: each sample runs four steps through the single 16x16
// multiplier (a*h1, b*h2, nibble*scale, then add and saturate), and the
// second sample waits for the first one's history.
// The output register holds a finished sample while the receiver stalls; the
// sequencer waits in its write step until the register frees, and s_axis_tready
// stays low until both samples of the byte have been written.
// Reset (arst_n low) clears history, scale, slice position and channel, loads
// a channel count of one, 18 slice bytes and zero coefficients, and empties
// the output. Configuration (cfg_*) must be written only while the block is
// idle; the block itself does not enforce this.

module adpcm_4bit_block_decoder_unit
	import adpcm_bd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tuser,   // [0] command
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,   // [15:0] pcm_sample, [18:16] channel_index,
	                                              // [27:19] sample_in_block, [31:28] zero
	output logic                  m_axis_tuser,   // [0] last_of_item
	output logic                  m_axis_tlast    // block_done
);

	// Sequencer state codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MA   = 3'd1;  // a * h1
	localparam logic [2:0] S_MB   = 3'd2;  // b * h2, move a*h1 to accumulator
	localparam logic [2:0] S_MN   = 3'd3;  // nibble * scale, accumulate b*h2
	localparam logic [2:0] S_WR   = 3'd4;  // add, saturate, write result

	// Configuration registers
	logic [3:0]               chan_count_q;
	logic [POS_W-1:0]         block_bytes_q;
	logic signed [COEF_W-1:0] coeff_a_q;
	logic signed [COEF_W-1:0] coeff_b_q;

	// Decoder state
	sample_t          hist1_q [MaxChannels];
	sample_t          hist2_q [MaxChannels];
	sample_t          scale_q;
	logic [POS_W-1:0] byte_pos_q;
	logic [CH_W-1:0]  chan_q;

	// Sequencer and per-byte working registers
	logic [2:0]          state_q;
	logic                nib_sel_q;
	logic [7:0]          byte_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic [POS_W-1:0]    base_q;
	logic                block_end_q;
	prod_t               prod_q;
	prod_t               acc_q;

	// Output register
	logic            out_valid_q;
	sample_t         out_pcm_q;
	logic [CH_W-1:0] out_ch_q;
	logic [SIB_W-1:0] out_sib_q;
	logic            out_last_q;
	logic            out_done_q;

	logic                s_fire;
	logic                slot_free;
	logic [CC_W-1:0]     cc_eff;
	logic [POS_W-1:0]    bb_eff;
	logic                slice_end;
	logic                block_end;
	logic [CH_IDX_W-1:0] ch_cur;
	logic signed [15:0]  mul_x;
	logic signed [15:0]  mul_y;
	logic [3:0]          nibble;
	prod_t               sum;
	sample_t             sat_val;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;

	// Clamp the configured counts to their usable ranges
	always_comb begin
		if (chan_count_q == 4'd0) begin
			cc_eff = CC_W'(1);
		end else if (32'(chan_count_q) > MaxChannels) begin
			cc_eff = CC_W'(MaxChannels);
		end else begin
			cc_eff = CC_W'(chan_count_q);
		end
		bb_eff = (block_bytes_q < BB_MIN) ? BB_MIN : block_bytes_q;
	end

	// Slice and block boundaries of the byte at the head of the stream
	assign ch_cur    = CH_IDX_W'(chan_q);
	assign slice_end = ({1'b0, byte_pos_q} + 9'd1) >= {1'b0, bb_eff};
	assign block_end = slice_end && ((32'(ch_cur) + 32'd1) >= 32'(cc_eff));

	// Select the multiplier operands for the current step
	assign nibble = nib_sel_q ? byte_q[3:0] : byte_q[7:4];
	always_comb begin
		case (state_q)
			S_MA: begin
				mul_x = 16'(coeff_a_q);
				mul_y = hist1_q[ch_q];
			end
			S_MB: begin
				mul_x = 16'(coeff_b_q);
				mul_y = hist2_q[ch_q];
			end
			default: begin
				mul_x = 16'(signed'(nibble));
				mul_y = scale_q;
			end
		endcase
	end

	// Add the scaled nibble to the floored prediction and saturate
	assign sum = prod_q + (acc_q >>> Q_SHIFT);
	always_comb begin
		if (sum > SAT_MAX) begin
			sat_val = 16'sh7fff;
		end else if (sum < SAT_MIN) begin
			sat_val = -16'sh8000;
		end else begin
			sat_val = sum[15:0];
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q  <= CC_RESET;
			block_bytes_q <= BB_RESET;
			coeff_a_q     <= '0;
			coeff_b_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHAN_COUNT:   chan_count_q  <= cfg_data[3:0];
				REG_BLOCK_BYTES:  block_bytes_q <= cfg_data[7:0];
				REG_PRED_COEFF_A: coeff_a_q     <= signed'(cfg_data[COEF_W-1:0]);
				REG_PRED_COEFF_B: coeff_b_q     <= signed'(cfg_data[COEF_W-1:0]);
				default: ;
			endcase
		end
	end

	// Sequencer, slice tracking and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nib_sel_q  <= 1'b0;
			scale_q    <= '0;
			byte_pos_q <= '0;
			chan_q     <= '0;
			for (int i = 0; i < MaxChannels; i++) begin
				hist1_q[i] <= '0;
				hist2_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						if (s_axis_tuser == CMD_RESTART) begin
							// clear history and restart at a block boundary
							for (int i = 0; i < MaxChannels; i++) begin
								hist1_q[i] <= '0;
								hist2_q[i] <= '0;
							end
							scale_q    <= '0;
							byte_pos_q <= '0;
							chan_q     <= '0;
						end else begin
							if (byte_pos_q == 8'd0) begin
								scale_q[15:8] <= s_axis_tdata;
							end else if (byte_pos_q == 8'd1) begin
								scale_q[7:0] <= s_axis_tdata;
							end else begin
								nib_sel_q <= 1'b0;
								state_q   <= S_MA;
							end
							// advance slice position and channel
							if (slice_end) begin
								byte_pos_q <= '0;
								chan_q     <= block_end ? '0 : CH_W'(ch_cur + 1'b1);
							end else begin
								byte_pos_q <= byte_pos_q + 1'b1;
							end
						end
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_MN;
				S_MN: state_q <= S_WR;
				S_WR: begin
					if (slot_free) begin
						hist2_q[ch_q] <= hist1_q[ch_q];
						hist1_q[ch_q] <= sat_val;
						if (nib_sel_q) begin
							state_q <= S_IDLE;
						end else begin
							nib_sel_q <= 1'b1;
							state_q   <= S_MA;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the per-byte context on every input transfer; only nibble bytes use it
	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_q      <= s_axis_tdata;
			ch_q        <= ch_cur;
			base_q      <= byte_pos_q - 8'd2;
			block_end_q <= block_end;
		end
	end

	// Shared multiplier with its product register and the accumulator
	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
		case (state_q)
			S_MB: acc_q <= prod_q;
			S_MN: acc_q <= acc_q + prod_q;
			default: ;
		endcase
	end

	// Output register: load in the write step, drop on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_WR && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WR && slot_free) begin
			out_pcm_q  <= sat_val;
			out_ch_q   <= CH_W'(ch_q);
			out_sib_q  <= {base_q, nib_sel_q};
			out_last_q <= nib_sel_q;
			out_done_q <= nib_sel_q && block_end_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_sib_q, out_ch_q, out_pcm_q};
	assign m_axis_tuser  = out_last_q;
	assign m_axis_tlast  = out_done_q;

`ifndef SYNTHESIS
	// A low-nibble sample sits at an odd position in the slice
	a_sib_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_sib_q[0] == out_last_q))
		else $error("sample position parity does not match nibble");

	// Block end is only flagged on the second sample of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_last_q)
		else $error("block_done without last_of_item");

	// The second sample's write returns the sequencer to idle
	a_byte_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && slot_free && nib_sel_q) |=> (state_q == S_IDLE))
		else $error("sequencer did not finish the byte");

	// A restart command lands at the start of channel 0
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tuser == CMD_RESTART) |=>
			(byte_pos_q == '0 && chan_q == '0 && scale_q == '0 && state_q == S_IDLE))
		else $error("restart did not clear slice state");
`endif

endmodule
